/* hdl/pf_pkg.sv */
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, codes and square arithmetic for the Playfair digram cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

    localparam int NUM_CELLS   = 25;
    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;
    localparam int CELL_W      = 5;

    localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;
    localparam logic [CELL_W-1:0]   CELL_LAST   = 5'd24;
    localparam logic [CELL_W-1:0]   FILL_FULL   = 5'd25;
    localparam logic [6:0]          ASCII_A     = 7'd97;

    // input operation codes
    localparam logic [2:0] OP_CLEAR_KEY = 3'd0;
    localparam logic [2:0] OP_KEY_BYTE  = 3'd1;
    localparam logic [2:0] OP_KEY_END   = 3'd2;
    localparam logic [2:0] OP_TEXT_BYTE = 3'd3;
    localparam logic [2:0] OP_TEXT_END  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [6:0] letter_out;
        logic       pair_end;
    } t_out_item;

    typedef enum logic [1:0] {
        PAIR_PEND_IN = 2'd0,
        PAIR_IN_X    = 2'd1,
        PAIR_PEND_X  = 2'd2
    } t_pair_sel;

    typedef struct packed {
        logic      clear_key;
        logic      place_in;
        logic      pend_load;
        logic      pend_clear;
        logic      pair_load;
        t_pair_sel pair_sel;
        logic      walk_start;
        logic      walk_place;
        logic      walk_step;
        logic      rd_pos_a;
        logic      rd_pos_b;
        logic      cap_pa;
        logic      cap_pb;
        logic      rd_sq1;
        logic      rd_sq2;
        logic      cap_c1;
        logic      cap_c2;
        logic      emit1;
        logic      emit2;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       is_letter;
        logic       can_place;
        logic       pend_valid;
        logic       pend_same;
        logic       decrypt;
        logic       walk_can_place;
        logic       walk_last;
        logic       out_busy;
    } t_dp_status;

    function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] p);
        logic [2:0] r;
        if (p < 5'd5)       r = 3'd0;
        else if (p < 5'd10) r = 3'd1;
        else if (p < 5'd15) r = 3'd2;
        else if (p < 5'd20) r = 3'd3;
        else                r = 3'd4;
        return r;
    endfunction

    function automatic logic [2:0] cell_col(input logic [CELL_W-1:0] p);
        logic [2:0] r;
        logic [CELL_W-1:0] base;
        r    = cell_row(p);
        base = {r, 2'b00} + {2'b00, r};
        return 3'(p - base);
    endfunction

    function automatic logic [CELL_W-1:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    // one step round the row or column: forward to encrypt, back to decrypt
    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
        logic [2:0] r;
        if (dec) r = (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
        else     r = (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/playfair_digram_cipher.sv */
// ----------------------------------------------------------------------------
// playfair_digram_cipher
// Playfair cipher over a 5x5 key square built from streamed key bytes.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       i_in_valid, o_in_stall, i_in_data         op and byte into the block
//  out      o_out_valid, i_out_stall, o_out_data      letter and pair end out
//  cfg      i_cfg_valid, o_cfg_ready, i_cfg_data      decrypt mode register
//
//  One word at a time. Key end walks the alphabet, one letter a cycle.
//  A digram steps through two position RAM reads and two square RAM reads
//  on single read ports, then two emits that output stall can hold; the
//  input is stalled until the digram is done.
//  Reset is synchronous, active low; the square and position RAMs are not
//  cleared and hold garbage until the key writes them.
//  Output stall holds the output register and the sequencer in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digram_cipher (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire pf_pkg::t_in_item  i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      pf_pkg::t_out_item o_out_data,
    input  wire logic              i_cfg_valid,
    output      logic              o_cfg_ready,
    input  wire logic              i_cfg_data
);

    pf_pkg::t_dp_cmd    cmd;
    pf_pkg::t_dp_status status;
    logic               in_ready;

    pf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    pf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* hdl/pf_ram.sv */
// ----------------------------------------------------------------------------
// pf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/pf_datapath.sv */
// ----------------------------------------------------------------------------
// pf_datapath
// Key square and letter position memories, key build state, pending letter,
// digram arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pf_pkg::t_in_item   i_in_data,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_data,
    input  wire logic               i_out_stall,
    input  wire pf_pkg::t_dp_cmd    i_cmd,
    output      pf_pkg::t_dp_status o_status,
    output      logic               o_out_valid,
    output      pf_pkg::t_out_item  o_out_data
);

    localparam int LW = pf_pkg::LETTER_W;
    localparam int CW = pf_pkg::CELL_W;

    logic                         r_decrypt, n_decrypt;
    logic [pf_pkg::NUM_LETTERS-1:0] r_seen, n_seen;
    logic [CW-1:0]                r_fill, n_fill;
    logic [LW-1:0]                r_pend, n_pend;
    logic                         r_pend_valid, n_pend_valid;
    logic [LW-1:0]                r_k, n_k;
    logic [LW-1:0]                r_la, n_la;
    logic [LW-1:0]                r_lb, n_lb;
    logic [CW-1:0]                r_pa, n_pa;
    logic [CW-1:0]                r_pb, n_pb;
    logic [LW-1:0]                r_c1, n_c1;
    logic [LW-1:0]                r_c2, n_c2;
    logic                         r_out_valid, n_out_valid;
    pf_pkg::t_out_item            r_out_data, n_out_data;

    logic          in_is_letter;
    logic [LW-1:0] in_raw;
    logic [LW-1:0] in_letter;
    logic          in_can_place;
    logic          walk_can_place;
    logic          out_busy;

    logic          place_we;
    logic [LW-1:0] place_letter;
    logic [CW-1:0] pos_rdata;
    logic [LW-1:0] sq_rdata;
    logic [LW-1:0] pos_raddr;
    logic [CW-1:0] sq_raddr;
    logic [CW-1:0] pos_clamped;

    logic [2:0]    ra, ca, rb, cb;
    logic          same_row, same_col;
    logic [CW-1:0] o1, o2;

    // letters map onto the low five bits of the ASCII code, less one
    always_comb begin
        in_is_letter = ((i_in_data.byte_in >= 8'h41) && (i_in_data.byte_in <= 8'h5A)) ||
                       ((i_in_data.byte_in >= 8'h61) && (i_in_data.byte_in <= 8'h7A));
        in_raw       = i_in_data.byte_in[4:0] - 5'd1;
        in_letter    = (in_raw == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : in_raw;
    end

    assign in_can_place   = in_is_letter && (r_fill < pf_pkg::FILL_FULL) && !r_seen[in_letter];
    assign walk_can_place = (r_k != pf_pkg::LETTER_J) && (r_fill < pf_pkg::FILL_FULL) &&
                            !r_seen[r_k];
    assign out_busy       = r_out_valid && i_out_stall;

    assign place_we     = i_cmd.place_in || i_cmd.walk_place;
    assign place_letter = i_cmd.place_in ? in_letter : r_k;
    assign pos_raddr    = i_cmd.rd_pos_a ? r_la : r_lb;
    assign pos_clamped  = (pos_rdata > pf_pkg::CELL_LAST) ? pf_pkg::CELL_LAST : pos_rdata;

    // digram rules
    always_comb begin
        ra       = pf_pkg::cell_row(r_pa);
        ca       = pf_pkg::cell_col(r_pa);
        rb       = pf_pkg::cell_row(r_pb);
        cb       = pf_pkg::cell_col(r_pb);
        same_row = (ra == rb);
        same_col = (ca == cb);
        if (same_row) begin
            o1 = pf_pkg::cell_at(ra, pf_pkg::wrap_step(ca, r_decrypt));
            o2 = pf_pkg::cell_at(rb, pf_pkg::wrap_step(cb, r_decrypt));
        end else if (same_col) begin
            o1 = pf_pkg::cell_at(pf_pkg::wrap_step(ra, r_decrypt), ca);
            o2 = pf_pkg::cell_at(pf_pkg::wrap_step(rb, r_decrypt), cb);
        end else begin
            o1 = pf_pkg::cell_at(ra, cb);
            o2 = pf_pkg::cell_at(rb, ca);
        end
    end

    assign sq_raddr = i_cmd.rd_sq1 ? o1 : o2;

    pf_ram #(
        .WIDTH (CW),
        .DEPTH (pf_pkg::NUM_LETTERS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (place_we),
        .i_waddr (place_letter),
        .i_wdata (r_fill),
        .i_re    (i_cmd.rd_pos_a || i_cmd.rd_pos_b),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    pf_ram #(
        .WIDTH (LW),
        .DEPTH (pf_pkg::NUM_CELLS)
    ) u_square_ram (
        .i_clk   (i_clk),
        .i_we    (place_we),
        .i_waddr (r_fill),
        .i_wdata (place_letter),
        .i_re    (i_cmd.rd_sq1 || i_cmd.rd_sq2),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    always_comb begin
        n_decrypt    = r_decrypt;
        n_seen       = r_seen;
        n_fill       = r_fill;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_k          = r_k;
        n_la         = r_la;
        n_lb         = r_lb;
        n_pa         = r_pa;
        n_pb         = r_pb;
        n_c1         = r_c1;
        n_c2         = r_c2;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        if (i_cfg_valid) begin
            n_decrypt = i_cfg_data;
        end

        if (i_cmd.clear_key) begin
            n_seen       = '0;
            n_fill       = '0;
            n_pend       = '0;
            n_pend_valid = 1'b0;
        end

        if (place_we) begin
            n_seen[place_letter] = 1'b1;
            if (place_letter == pf_pkg::LETTER_I) begin
                n_seen[pf_pkg::LETTER_J] = 1'b1;
            end
            n_fill = r_fill + 5'd1;
        end

        if (i_cmd.walk_start) begin
            n_k = '0;
        end else if (i_cmd.walk_step) begin
            n_k = r_k + 5'd1;
        end

        if (i_cmd.pend_load) begin
            n_pend       = in_letter;
            n_pend_valid = 1'b1;
        end else if (i_cmd.pend_clear) begin
            n_pend_valid = 1'b0;
        end

        if (i_cmd.pair_load) begin
            case (i_cmd.pair_sel)
                pf_pkg::PAIR_PEND_IN: begin
                    n_la = r_pend;
                    n_lb = in_letter;
                end
                pf_pkg::PAIR_IN_X: begin
                    n_la = in_letter;
                    n_lb = pf_pkg::LETTER_X;
                end
                pf_pkg::PAIR_PEND_X: begin
                    n_la = r_pend;
                    n_lb = pf_pkg::LETTER_X;
                end
                default: begin
                    n_la = r_pend;
                    n_lb = pf_pkg::LETTER_X;
                end
            endcase
        end

        if (i_cmd.cap_pa) n_pa = pos_clamped;
        if (i_cmd.cap_pb) n_pb = pos_clamped;
        if (i_cmd.cap_c1) n_c1 = sq_rdata;
        if (i_cmd.cap_c2) n_c2 = sq_rdata;

        // output register: drop a taken word, load on emit
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit1 || i_cmd.emit2) begin
            n_out_valid           = 1'b1;
            n_out_data.letter_out = pf_pkg::ASCII_A +
                                    {2'b00, (i_cmd.emit1 ? r_c1 : r_c2)};
            n_out_data.pair_end   = i_cmd.emit2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt    <= 1'b0;
            r_seen       <= '0;
            r_fill       <= '0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_decrypt    <= n_decrypt;
            r_seen       <= n_seen;
            r_fill       <= n_fill;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_la       <= n_la;
        r_lb       <= n_lb;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_c1       <= n_c1;
        r_c2       <= n_c2;
        r_out_data <= n_out_data;
    end

    always_comb begin
        o_status.op             = i_in_data.op;
        o_status.is_letter      = in_is_letter;
        o_status.can_place      = in_can_place;
        o_status.pend_valid     = r_pend_valid;
        o_status.pend_same      = (r_pend == in_letter);
        o_status.decrypt        = r_decrypt;
        o_status.walk_can_place = walk_can_place;
        o_status.walk_last      = (r_k == pf_pkg::LETTER_LAST);
        o_status.out_busy       = out_busy;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* hdl/pf_ctrl.sv */
// ----------------------------------------------------------------------------
// pf_ctrl
// Sequencer: decodes each accepted word, walks the alphabet at key end and
// steps a digram through position reads, square reads and two emits.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pf_pkg::t_dp_status i_status,
    output      pf_pkg::t_dp_cmd    o_cmd,
    output      logic               o_in_ready
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_WALK   = 10'b00_0000_0010,
        S_RD_A   = 10'b00_0000_0100,
        S_RD_B   = 10'b00_0000_1000,
        S_GET_B  = 10'b00_0001_0000,
        S_RD_S1  = 10'b00_0010_0000,
        S_RD_S2  = 10'b00_0100_0000,
        S_GET_S2 = 10'b00_1000_0000,
        S_EMIT1  = 10'b01_0000_0000,
        S_EMIT2  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_status.op)
                        pf_pkg::OP_CLEAR_KEY: begin
                            o_cmd.clear_key = 1'b1;
                        end
                        pf_pkg::OP_KEY_BYTE: begin
                            o_cmd.place_in = i_status.can_place;
                        end
                        pf_pkg::OP_KEY_END: begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                        pf_pkg::OP_TEXT_BYTE: begin
                            if (i_status.is_letter) begin
                                if (!i_status.pend_valid) begin
                                    o_cmd.pend_load = 1'b1;
                                end else if (!i_status.decrypt && i_status.pend_same) begin
                                    // doubled letter: split with x, keep it pending
                                    o_cmd.pair_load = 1'b1;
                                    o_cmd.pair_sel  = pf_pkg::PAIR_IN_X;
                                    n_state         = S_RD_A;
                                end else begin
                                    o_cmd.pend_clear = 1'b1;
                                    o_cmd.pair_load  = 1'b1;
                                    o_cmd.pair_sel   = pf_pkg::PAIR_PEND_IN;
                                    n_state          = S_RD_A;
                                end
                            end
                        end
                        pf_pkg::OP_TEXT_END: begin
                            if (i_status.pend_valid) begin
                                o_cmd.pend_clear = 1'b1;
                                if (!i_status.decrypt) begin
                                    o_cmd.pair_load = 1'b1;
                                    o_cmd.pair_sel  = pf_pkg::PAIR_PEND_X;
                                    n_state         = S_RD_A;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk_place = i_status.walk_can_place;
                o_cmd.walk_step  = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_A: begin
                o_cmd.rd_pos_a = 1'b1;
                n_state        = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.rd_pos_b = 1'b1;
                o_cmd.cap_pa   = 1'b1;
                n_state        = S_GET_B;
            end
            S_GET_B: begin
                o_cmd.cap_pb = 1'b1;
                n_state      = S_RD_S1;
            end
            S_RD_S1: begin
                o_cmd.rd_sq1 = 1'b1;
                n_state      = S_RD_S2;
            end
            S_RD_S2: begin
                o_cmd.rd_sq2 = 1'b1;
                o_cmd.cap_c1 = 1'b1;
                n_state      = S_GET_S2;
            end
            S_GET_S2: begin
                o_cmd.cap_c2 = 1'b1;
                n_state      = S_EMIT1;
            end
            S_EMIT1: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit1 = 1'b1;
                    n_state     = S_EMIT2;
                end
            end
            S_EMIT2: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit2 = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/pf_checker.sv */
// ----------------------------------------------------------------------------
// pf_checker
// Port-level checks on the cipher's handshake behaviour, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire pf_pkg::t_in_item  i_in_data,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire pf_pkg::t_out_item o_out_data
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output word changed under stall");

    // a stalled input word holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input word changed under stall");

    // nothing is presented straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input is held off while a digram is half delivered
    a_half_pair_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.pair_end) |-> o_in_stall)
        else $error("input accepted mid digram");

    // the second letter follows at once when the first is taken
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.pair_end && !i_out_stall)
        |=> (o_out_valid && o_out_data.pair_end))
        else $error("second letter of digram missing");

endmodule

bind playfair_digram_cipher pf_checker u_pf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
